// ===== rtl/onre_pkg.sv =====
package onre_pkg;

  localparam int FracBits = 15;
  localparam int OneQ     = 1 << FracBits;
  localparam int SinEps   = (OneQ + 5000) / 10000;
  localparam int TanMax   = (16 << FracBits) - 1;
  localparam logic [31:0] InvPiQ32 = 32'd1367130551;
  localparam int ChMax    = 65535;

  localparam int SqrtW = 16;
  localparam int DivQw = 19;

  typedef enum logic [2:0] {
    REG_COEF_A   = 3'd0,
    REG_COEF_B   = 3'd1,
    REG_ALB_RED  = 3'd2,
    REG_ALB_GRN  = 3'd3,
    REG_ALB_BLU  = 3'd4
  } reg_idx_t;

endpackage

// ===== rtl/oren_nayar_reflectance_eval.sv =====
// Oren-Nayar reflectance evaluator, fully pipelined.
// start propagates to done through the input, square-root, selection, division, product and output registers.
// Throughput: one item per clock cycle; busy is held low, so start may be high every cycle.
// The longest part is the chain of shared-nothing restoring division and square-root
// stages, one result bit per stage.
// Reset (rst, synchronous) clears all valid bits and loads the register defaults.
module oren_nayar_reflectance_eval (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic signed [15:0] out_x,
  input  logic signed [15:0] out_y,
  input  logic signed [15:0] out_z,
  input  logic signed [15:0] in_x,
  input  logic signed [15:0] in_y,
  input  logic signed [15:0] in_z,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        done,
  output logic [15:0] red,
  output logic [15:0] green,
  output logic [15:0] blue,
  output logic        clipped
);

  // Configuration registers.
  logic [15:0] coef_a, coef_b, alb_r, alb_g, alb_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a <= 16'd32768;
      coef_b <= 16'd0;
      alb_r  <= 16'hFFFF;
      alb_g  <= 16'hFFFF;
      alb_b  <= 16'hFFFF;
    end else if (cfg_we) begin
      case (cfg_index)
        onre_pkg::REG_COEF_A:  coef_a <= cfg_data;
        onre_pkg::REG_COEF_B:  coef_b <= cfg_data;
        onre_pkg::REG_ALB_RED: alb_r  <= cfg_data;
        onre_pkg::REG_ALB_GRN: alb_g  <= cfg_data;
        onre_pkg::REG_ALB_BLU: alb_b  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Stage numbering. The pipeline runs in phases:
  //   S0          : input register, z squared
  //   SQ 16 steps : square roots of both sides, one root bit per stage
  //   SEL         : epsilon test, choose alpha/beta, tangent overflow test
  //   DV 19 steps : five divisions in parallel (four azimuth ratios, tangent)
  //   then products, coefficient scaling, the channel products, the 1/pi scaling and output saturation.
  localparam int Sq = onre_pkg::SqrtW;
  localparam int Dq = onre_pkg::DivQw;

  logic accept;
  assign accept = start & ~busy;

  // ---------------- stage 0 ----------------
  logic        v0;
  logic signed [15:0] ox0, oy0, ix0, iy0;
  logic [15:0] aco0, aci0;
  logic [31:0] rem_o0, rem_i0;
  logic [31:0] zo2, zi2;
  logic [32:0] so2, si2;

  always_comb begin
    zo2 = 32'(($signed(out_z) * $signed(out_z)));
    zi2 = 32'(($signed(in_z) * $signed(in_z)));
    so2 = 33'(1 << (2 * onre_pkg::FracBits)) - {1'b0, zo2};
    si2 = 33'(1 << (2 * onre_pkg::FracBits)) - {1'b0, zi2};
  end

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else     v0 <= accept;
    ox0 <= out_x; oy0 <= out_y; ix0 <= in_x; iy0 <= in_y;
    aco0 <= out_z[15] ? 16'(-out_z) : out_z;
    aci0 <= in_z[15]  ? 16'(-in_z)  : in_z;
    rem_o0 <= so2[32] ? 32'd0 : so2[31:0];
    rem_i0 <= si2[32] ? 32'd0 : si2[31:0];
  end

  // ---------------- square root stages ----------------
  // Restoring digit-by-digit root: 16 stages, each produces one root bit.
  logic               sv   [Sq+1];
  logic signed [15:0] sox  [Sq+1], soy [Sq+1], six [Sq+1], siy [Sq+1];
  logic [15:0]        saco [Sq+1], saci[Sq+1];
  logic [31:0]        sro  [Sq+1], sri [Sq+1];
  logic [33:0]        sremo[Sq+1], sremi[Sq+1];
  logic [15:0]        sqo  [Sq+1], sqi [Sq+1];

  assign sv[0] = v0;  assign sox[0] = ox0; assign soy[0] = oy0;
  assign six[0] = ix0; assign siy[0] = iy0;
  assign saco[0] = aco0; assign saci[0] = aci0;
  assign sro[0] = rem_o0; assign sri[0] = rem_i0;
  assign sremo[0] = '0; assign sremi[0] = '0;
  assign sqo[0] = '0; assign sqi[0] = '0;

  for (genvar k = 0; k < Sq; k++) begin : g_sqrt
    logic [33:0] ro, ri, to, ti;
    always_comb begin
      ro = {sremo[k][31:0], sro[k][31:30]};
      ri = {sremi[k][31:0], sri[k][31:30]};
      to = ro - {16'd0, sqo[k], 2'b01};
      ti = ri - {16'd0, sqi[k], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (rst) sv[k+1] <= 1'b0;
      else     sv[k+1] <= sv[k];
      sox[k+1] <= sox[k]; soy[k+1] <= soy[k];
      six[k+1] <= six[k]; siy[k+1] <= siy[k];
      saco[k+1] <= saco[k]; saci[k+1] <= saci[k];
      sro[k+1] <= {sro[k][29:0], 2'b00};
      sri[k+1] <= {sri[k][29:0], 2'b00};
      sremo[k+1] <= to[33] ? ro : to;
      sremi[k+1] <= ti[33] ? ri : ti;
      sqo[k+1] <= {sqo[k][14:0], ~to[33]};
      sqi[k+1] <= {sqi[k][14:0], ~ti[33]};
    end
  end

  // ---------------- selection stage ----------------
  logic        v1, both1, tclip1;
  logic [15:0] sina1, sinb1, cosb1;
  logic [15:0] sino1, sini1;
  logic signed [15:0] ox1, oy1, ix1, iy1;

  always_ff @(posedge clk) begin
    logic [15:0] so, si, sb, cb;
    so = sqo[Sq]; si = sqi[Sq];
    if (rst) v1 <= 1'b0;
    else     v1 <= sv[Sq];
    both1 <= (32'(si) > 32'(onre_pkg::SinEps)) && (32'(so) > 32'(onre_pkg::SinEps));
    if (saci[Sq] > saco[Sq]) begin
      sb = si; cb = saci[Sq]; sina1 <= so;
    end else begin
      sb = so; cb = saco[Sq]; sina1 <= si;
    end
    sinb1 <= sb; cosb1 <= cb;
    tclip1 <= {4'd0, sb} >= {cb, 4'd0};
    sino1 <= so; sini1 <= si;
    ox1 <= sox[Sq]; oy1 <= soy[Sq]; ix1 <= six[Sq]; iy1 <= siy[Sq];
  end

  // ---------------- division stages ----------------
  // Five unsigned restoring divisions of (|num| << 15) by a 16-bit divisor.
  // Quotients are 19 bits wide, which holds every unsaturated tangent; the top
  // bit is sticky for the azimuth ratios, which clamp to one anyway.
  // Lane 0..3: azimuth ratios (cpi, spi, cpo, spo). Lane 4: tan(beta).
  localparam int NL = 5;
  logic              dv   [Dq+1];
  logic              dboth[Dq+1], dtc[Dq+1];
  logic [15:0]       dsina[Dq+1];
  logic [31:0]       dnum [Dq+1][NL];
  logic [15:0]       dden [Dq+1][NL];
  logic [16:0]       drem [Dq+1][NL];
  logic [Dq-1:0]     dquo [Dq+1][NL];
  logic [NL-1:0]     dneg [Dq+1];

  always_comb begin
    logic [15:0] ax [4];
    logic [15:0] dn [4];
    ax[0] = ix1[15] ? 16'(-ix1) : ix1;
    ax[1] = iy1[15] ? 16'(-iy1) : iy1;
    ax[2] = ox1[15] ? 16'(-ox1) : ox1;
    ax[3] = oy1[15] ? 16'(-oy1) : oy1;
    dn[0] = sini1; dn[1] = sini1; dn[2] = sino1; dn[3] = sino1;
    for (int l = 0; l < 4; l++) begin
      dnum[0][l] = {1'b0, ax[l], 15'd0};
      dden[0][l] = (dn[l] == 16'd0) ? 16'd1 : dn[l];
      drem[0][l] = '0;
      dquo[0][l] = '0;
    end
    dnum[0][4] = {1'b0, sinb1, 15'd0};
    dden[0][4] = (cosb1 == 16'd0) ? 16'd1 : cosb1;
    drem[0][4] = '0;
    dquo[0][4] = '0;
    dneg[0] = {1'b0, oy1[15], ox1[15], iy1[15], ix1[15]};
  end
  assign dv[0] = v1; assign dboth[0] = both1; assign dtc[0] = tclip1;
  assign dsina[0] = sina1;

  // The numerator is below 2^31, so its top bit is zero and 31 quotient bits
  // could arise; bits above 2^18 only matter as saturation, which the upper
  // part of the numerator decides. The first stage pre-loads the upper
  // remainder from numerator bits [30:18].
  for (genvar k = 0; k < Dq; k++) begin : g_div
    always_ff @(posedge clk) begin
      logic [16:0] r;
      logic [17:0] t;
      if (rst) dv[k+1] <= 1'b0;
      else     dv[k+1] <= dv[k];
      dboth[k+1] <= dboth[k]; dtc[k+1] <= dtc[k]; dsina[k+1] <= dsina[k];
      dneg[k+1] <= dneg[k];
      for (int l = 0; l < NL; l++) begin
        dden[k+1][l] <= dden[k][l];
        if (k == 0) begin
          // Upper 13 bits: if they reach the divisor the quotient is at least 2^18;
          // that bit then works as a sticky flag through the top quotient bit.
          r = {4'b0000, dnum[k][l][30:18]};
          t = {1'b0, r} - {2'd0, dden[k][l]};
          drem[k+1][l] <= t[17] ? r : t[16:0];
          dquo[k+1][l] <= {{(Dq-1){1'b0}}, ~t[17]};
          dnum[k+1][l] <= {dnum[k][l][17:0], 14'd0};
        end else begin
          r = {drem[k][l][15:0], dnum[k][l][31]};
          t = {1'b0, r} - {2'd0, dden[k][l]};
          drem[k+1][l] <= t[17] ? r : t[16:0];
          dquo[k+1][l] <= {dquo[k][l][Dq-2:0] | {{(Dq-2){1'b0}}, dquo[k][l][Dq-1]},
                           ~t[17]} | {dquo[k][l][Dq-1] & (k == 1), {(Dq-1){1'b0}}};
          dnum[k+1][l] <= {dnum[k][l][30:0], 1'b0};
        end
      end
    end
  end

  // ---------------- post-division: azimuth products ----------------
  logic        v2, both2, tc2;
  logic [15:0] sina2;
  logic signed [16:0] cpi2, spi2, cpo2, spo2;
  logic [19:0] tan2;

  function automatic logic signed [16:0] clamp_ratio(input logic [Dq-1:0] q,
                                                     input logic neg);
    logic [16:0] m;
    m = (q > Dq'(onre_pkg::OneQ)) ? 17'(onre_pkg::OneQ) : q[16:0];
    return neg ? -$signed(m) : $signed(m);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= dv[Dq];
    both2 <= dboth[Dq]; tc2 <= dtc[Dq]; sina2 <= dsina[Dq];
    cpi2 <= clamp_ratio(dquo[Dq][0], dneg[Dq][0]);
    spi2 <= clamp_ratio(dquo[Dq][1], dneg[Dq][1]);
    cpo2 <= clamp_ratio(dquo[Dq][2], dneg[Dq][2]);
    spo2 <= clamp_ratio(dquo[Dq][3], dneg[Dq][3]);
    tan2 <= dtc[Dq] ? 20'(onre_pkg::TanMax) : 20'(dquo[Dq][4]);
  end

  logic        v3, both3, tc3;
  logic [15:0] sina3;
  logic [19:0] tan3;
  logic signed [33:0] pc3, ps3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
    both3 <= both2; tc3 <= tc2; sina3 <= sina2; tan3 <= tan2;
    pc3 <= cpi2 * cpo2;
    ps3 <= spi2 * spo2;
  end

  logic        v4, tc4;
  logic [15:0] sina4;
  logic [19:0] tan4;
  logic [16:0] dcos4;
  always_ff @(posedge clk) begin
    logic signed [34:0] s;
    logic signed [34:0] d;
    s = 35'(pc3) + 35'(ps3);
    // Division by 2^15 rounding toward minus infinity; negative results clamp to zero anyway.
    d = s >>> onre_pkg::FracBits;
    if (rst) v4 <= 1'b0;
    else     v4 <= v3;
    tc4 <= tc3; sina4 <= sina3; tan4 <= tan3;
    if (!both3 || s < 0) dcos4 <= '0;
    else if (d > 35'(onre_pkg::OneQ)) dcos4 <= 17'(onre_pkg::OneQ);
    else dcos4 <= d[16:0];
  end

  logic        v5, tc5;
  logic [19:0] tan5;
  logic [17:0] p5;
  always_ff @(posedge clk) begin
    logic [32:0] m;
    m = dcos4 * sina4;
    if (rst) v5 <= 1'b0;
    else     v5 <= v4;
    tc5 <= tc4; tan5 <= tan4;
    p5 <= m[32:15];
  end

  logic        v6, tc6;
  logic [22:0] p6;
  always_ff @(posedge clk) begin
    logic [37:0] m;
    m = p5 * tan5;
    if (rst) v6 <= 1'b0;
    else     v6 <= v5;
    tc6 <= tc5;
    p6 <= m[37:15];
  end

  logic        v7, tc7;
  logic [24:0] fac7;
  always_ff @(posedge clk) begin
    logic [38:0] m;
    m = p6 * coef_b;
    if (rst) v7 <= 1'b0;
    else     v7 <= v6;
    tc7 <= tc6;
    fac7 <= 25'(m[38:15]) + 25'(coef_a);
  end

  logic        v8, tc8;
  logic [25:0] c8 [3];
  always_ff @(posedge clk) begin
    logic [40:0] m [3];
    m[0] = fac7 * alb_r; m[1] = fac7 * alb_g; m[2] = fac7 * alb_b;
    if (rst) v8 <= 1'b0;
    else     v8 <= v7;
    tc8 <= tc7;
    for (int c = 0; c < 3; c++) c8[c] <= m[c][40:15];
  end

  // 26 by 32 product, split into two partial products over two stages.
  logic        v9, tc9;
  logic [41:0] lo9 [3];
  logic [25:0] cc9 [3];
  always_ff @(posedge clk) begin
    if (rst) v9 <= 1'b0;
    else     v9 <= v8;
    tc9 <= tc8;
    for (int c = 0; c < 3; c++) begin
      lo9[c] <= c8[c] * onre_pkg::InvPiQ32[15:0];
      cc9[c] <= c8[c];
    end
  end

  logic        v10, tc10;
  logic [57:0] pr10 [3];
  always_ff @(posedge clk) begin
    logic [41:0] h;
    if (rst) v10 <= 1'b0;
    else     v10 <= v9;
    tc10 <= tc9;
    for (int c = 0; c < 3; c++) begin
      h = cc9[c] * onre_pkg::InvPiQ32[31:16];
      pr10[c] <= {h, 16'd0} + 58'(lo9[c]);
    end
  end

  always_ff @(posedge clk) begin
    logic [21:0] v [3];
    logic        sat;
    if (rst) done <= 1'b0;
    else     done <= v10;
    sat = 1'b0;
    for (int c = 0; c < 3; c++) begin
      v[c] = pr10[c][57:36];
      if (v[c] > 22'(onre_pkg::ChMax)) sat = 1'b1;
    end
    red   <= (v[0] > 22'(onre_pkg::ChMax)) ? 16'hFFFF : v[0][15:0];
    green <= (v[1] > 22'(onre_pkg::ChMax)) ? 16'hFFFF : v[1][15:0];
    blue  <= (v[2] > 22'(onre_pkg::ChMax)) ? 16'hFFFF : v[2][15:0];
    clipped <= tc10 | sat;
  end

  // Assertions.
  a_valid_chain: assert property (@(posedge clk) disable iff (rst) v10 |=> done)
    else $error("valid lost at output");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst) !v10 |=> !done)
    else $error("spurious done");
  a_tan_clip: assert property (@(posedge clk) disable iff (rst)
    v2 && tc2 |-> tan2 == 20'(onre_pkg::TanMax))
    else $error("tangent not saturated");
  a_dcos_range: assert property (@(posedge clk) disable iff (rst)
    v4 |-> dcos4 <= 17'(onre_pkg::OneQ))
    else $error("dcos out of range");

endmodule
